### src/dtse_pkg.sv
`timescale 1ns / 1ps
package dtse_pkg;

  localparam int NODE_W        = 5;
  localparam int MAX_NODES_DEF = 32;

  localparam logic [1:0] ACT_ADD_NODE = 2'd0;
  localparam logic [1:0] ACT_ADD_EDGE = 2'd1;
  localparam logic [1:0] ACT_TEST_CYC = 2'd2;
  localparam logic [1:0] ACT_SORT     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP_NODE  = 3'd1;
  localparam logic [2:0] ST_WOULD_CYC = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_HAS_CYC   = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_REACH,
    S_DEG,
    S_SEED,
    S_ENQ,
    S_POP,
    S_POPW,
    S_ROW,
    S_CHK,
    S_EMRD,
    S_EMOUT,
    S_RESP
  } state_t;

  // Commands to the in-degree lanes.
  typedef struct packed {
    logic clr;
    logic acc;
    logic dec;
  } lane_ctl_t;

endpackage

### src/dtse_deg_lanes.sv
`timescale 1ns / 1ps
module dtse_deg_lanes #(
  parameter int NODES = dtse_pkg::MAX_NODES_DEF
) (
  input  logic                clk,
  input  dtse_pkg::lane_ctl_t ctl,
  input  logic [NODES-1:0]    row,
  input  logic [NODES-1:0]    present,
  output logic [NODES-1:0]    zero_mask,
  output logic [NODES-1:0]    newly
);
  import dtse_pkg::*;

  localparam int DW = $clog2(NODES + 1);

  logic [DW-1:0] deg_r [NODES];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NODES; i++) begin
      if (ctl.clr) begin
        deg_r[i] <= '0;
      end else if (ctl.acc && row[i] && present[i]) begin
        deg_r[i] <= deg_r[i] + DW'(1);
      end else if (ctl.dec && row[i] && present[i] && (deg_r[i] != '0)) begin
        deg_r[i] <= deg_r[i] - DW'(1);
      end
    end
  end

  // A lane whose count is one and whose edge is removed now becomes ready.
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      zero_mask[i] = present[i] && (deg_r[i] == '0);
      newly[i]     = present[i] && row[i] && (deg_r[i] == DW'(1));
    end
  end

endmodule

### src/dag_topological_sort_engine_unit.sv
`timescale 1ns / 1ps
// Channel  Ports                                              Dir
// in       in_valid in_ready in_action in_first_node           input
//          in_second_node
// out      out_valid out_ready out_status out_order_node       output
//          out_order_valid out_last
// Add node is settled on accept; add edge reads the row, then writes it. A cycle
// test walks the adjacency rows in passes, at most NL, bound by the one read
// port of the adjacency memory. A sort counts in-degrees over all rows, pops
// each sorted node, reads its row, enqueues newly ready nodes, then emits each
// beat. Reset clears the node set and the row valid bits at once; there is no
// clearing pass. A stalled output holds the sequencer in its emitting state.
module dag_topological_sort_engine_unit #(
  parameter int MAX_NODES = dtse_pkg::MAX_NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [dtse_pkg::NODE_W-1:0]   in_first_node,
  input  logic [dtse_pkg::NODE_W-1:0]   in_second_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_status,
  output logic [dtse_pkg::NODE_W-1:0]   out_order_node,
  output logic                          out_order_valid,
  output logic                          out_last
);
  import dtse_pkg::*;

  localparam int NL = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int IW = $clog2(NL);
  localparam int CW = $clog2(NL + 1);

  // Adjacency memory with a valid bit per row; an unwritten row reads as zero.
  logic [NL-1:0] adj_mem [NL];
  logic [NL-1:0] row_valid_r;
  logic [NL-1:0] adj_raw_r;
  logic          adj_vq_r;
  logic [NL-1:0] adj_q;
  logic [IW-1:0] adj_ra;
  logic          adj_we;
  logic [NL-1:0] adj_wd;

  // Ready queue, which in the end holds the topological order.
  logic [NODE_W-1:0] q_mem [NL];
  logic [NODE_W-1:0] q_q_r;
  logic [IW-1:0]     q_ra;
  logic              q_we;
  logic [NODE_W-1:0] q_wd;

  state_t            state_r, state_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [NODE_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [NL-1:0]     present_r, present_nxt;
  logic [NL-1:0]     visited_r, visited_nxt;
  logic              changed_r, changed_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              issue_r, issue_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     pi_r, pi_nxt;
  logic [CW-1:0]     head_r, head_nxt, tail_r, tail_nxt, pcnt_r, pcnt_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [NL-1:0]     pend_r, pend_nxt;
  logic [2:0]        stat_r, stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic              out_ov_r, out_ov_nxt;
  logic              out_last_r, out_last_nxt;

  lane_ctl_t     lctl;
  logic [NL-1:0] zero_mask, newly;

  logic          accept, out_free;
  logic          in_a_ok, in_b_ok;
  logic [NL-1:0] low_bit, vis_new;
  logic [IW-1:0] low_idx;
  logic          chg_new;

  dtse_deg_lanes #(.NODES(NL)) u_lanes (
    .clk       (clk),
    .ctl       (lctl),
    .row       (adj_q),
    .present   (present_r),
    .zero_mask (zero_mask),
    .newly     (newly)
  );

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[a_r[IW-1:0]] <= adj_wd;
    end
    adj_raw_r <= adj_mem[adj_ra];
    adj_vq_r  <= row_valid_r[adj_ra];
  end
  assign adj_q = adj_vq_r ? adj_raw_r : '0;

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r[IW-1:0]] <= q_wd;
    end
    q_q_r <= q_mem[q_ra];
  end

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_a_ok  = 32'(in_first_node) < NL;
  assign in_b_ok  = 32'(in_second_node) < NL;

  always_comb begin
    low_bit = pend_r & (~pend_r + NL'(1));
    low_idx = '0;
    for (int i = 0; i < NL; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | IW'(i);
      end
    end
  end

  // One reachability step: a visited row spreads its successors.
  always_comb begin
    vis_new = visited_r;
    chg_new = changed_r;
    if (pv_r && visited_r[pi_r]) begin
      vis_new = visited_r | adj_q;
      chg_new = changed_r || ((adj_q & ~visited_r) != '0);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    present_nxt    = present_r;
    visited_nxt    = visited_r;
    changed_nxt    = changed_r;
    idx_nxt        = idx_r;
    issue_nxt      = issue_r;
    pv_nxt         = 1'b0;
    pi_nxt         = idx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    pcnt_nxt       = pcnt_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_node_nxt   = out_node_r;
    out_ov_nxt     = out_ov_r;
    out_last_nxt   = out_last_r;
    lctl           = '0;
    adj_ra         = idx_r;
    adj_we         = 1'b0;
    adj_wd         = adj_q | (NL'(1) << b_r[IW-1:0]);
    q_ra           = head_r[IW-1:0];
    q_we           = 1'b0;
    q_wd           = NODE_W'(low_idx);
    in_ready       = (state_r == S_IDLE);

    if ((state_r == S_REACH || state_r == S_DEG) && issue_r) begin
      pv_nxt  = 1'b1;
      idx_nxt = idx_r + IW'(1);
      if (32'(idx_r) == NL - 1) begin
        issue_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt  = in_action;
          a_nxt    = in_first_node;
          b_nxt    = in_second_node;
          stat_nxt = ST_OK;
          unique case (in_action)
            ACT_ADD_NODE: begin
              if (in_a_ok && present_r[in_first_node[IW-1:0]]) begin
                stat_nxt = ST_DUP_NODE;
              end else if (in_a_ok) begin
                present_nxt[in_first_node[IW-1:0]] = 1'b1;
              end
              state_nxt = S_RESP;
            end
            ACT_ADD_EDGE: begin
              state_nxt = (in_a_ok && in_b_ok) ? S_EDGE_RD : S_RESP;
            end
            ACT_TEST_CYC: begin
              if (!(in_a_ok && in_b_ok)) begin
                state_nxt = S_RESP;
              end else if (in_first_node == in_second_node) begin
                stat_nxt  = ST_WOULD_CYC;
                state_nxt = S_RESP;
              end else begin
                visited_nxt = NL'(1) << in_second_node[IW-1:0];
                changed_nxt = 1'b0;
                idx_nxt     = '0;
                issue_nxt   = 1'b1;
                state_nxt   = S_REACH;
              end
            end
            ACT_SORT: begin
              if (present_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                lctl.clr  = 1'b1;
                pcnt_nxt  = '0;
                idx_nxt   = '0;
                issue_nxt = 1'b1;
                state_nxt = S_DEG;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE_RD: begin
        adj_ra    = a_r[IW-1:0];
        state_nxt = S_EDGE_WR;
      end
      S_EDGE_WR: begin
        adj_we    = 1'b1;
        state_nxt = S_RESP;
      end
      S_REACH: begin
        visited_nxt = vis_new;
        changed_nxt = chg_new;
        if (pv_r && 32'(pi_r) == NL - 1) begin
          if (vis_new[a_r[IW-1:0]]) begin
            stat_nxt  = ST_WOULD_CYC;
            state_nxt = S_RESP;
          end else if (!chg_new) begin
            state_nxt = S_RESP;
          end else begin
            changed_nxt = 1'b0;
            idx_nxt     = '0;
            issue_nxt   = 1'b1;
          end
        end
      end
      S_DEG: begin
        if (pv_r) begin
          lctl.acc = 1'b1;
          if (present_r[pi_r]) begin
            pcnt_nxt = pcnt_r + CW'(1);
          end
          if (32'(pi_r) == NL - 1) begin
            state_nxt = S_SEED;
          end
        end
      end
      S_SEED: begin
        pend_nxt  = zero_mask;
        head_nxt  = '0;
        tail_nxt  = '0;
        state_nxt = S_ENQ;
      end
      S_ENQ: begin
        if (pend_r != '0) begin
          q_we     = 1'b1;
          pend_nxt = pend_r & ~low_bit;
          tail_nxt = tail_r + CW'(1);
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        state_nxt = (head_r == tail_r) ? S_CHK : S_POPW;
      end
      S_POPW: begin
        adj_ra    = q_q_r[IW-1:0];
        state_nxt = S_ROW;
      end
      S_ROW: begin
        lctl.dec  = 1'b1;
        pend_nxt  = newly;
        head_nxt  = head_r + CW'(1);
        state_nxt = S_ENQ;
      end
      S_CHK: begin
        if (tail_r == pcnt_r) begin
          k_nxt     = '0;
          state_nxt = S_EMRD;
        end else begin
          stat_nxt  = ST_HAS_CYC;
          state_nxt = S_RESP;
        end
      end
      S_EMRD: begin
        q_ra      = k_r[IW-1:0];
        state_nxt = S_EMOUT;
      end
      S_EMOUT: begin
        q_ra = k_r[IW-1:0];
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_node_nxt   = q_q_r;
          out_ov_nxt     = 1'b1;
          out_last_nxt   = (k_r + CW'(1)) == tail_r;
          k_nxt          = k_r + CW'(1);
          state_nxt      = ((k_r + CW'(1)) == tail_r) ? S_IDLE : S_EMRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_node_nxt   = '0;
          out_ov_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      present_r   <= '0;
      row_valid_r <= '0;
      issue_r     <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      present_r   <= present_nxt;
      issue_r     <= issue_nxt;
      pv_r        <= pv_nxt;
      if (adj_we) begin
        row_valid_r[a_r[IW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    visited_r    <= visited_nxt;
    changed_r    <= changed_nxt;
    idx_r        <= idx_nxt;
    pi_r         <= pi_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    pcnt_r       <= pcnt_nxt;
    k_r          <= k_nxt;
    pend_r       <= pend_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_node_r   <= out_node_nxt;
    out_ov_r     <= out_ov_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_order_node  = out_node_r;
  assign out_order_valid = out_ov_r;
  assign out_last        = out_last_r;

  a_sort_only_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMOUT) |-> (act_r == ACT_SORT))
    else $error("order emitted outside a sort");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP || state_r == S_CHK) |-> (head_r <= tail_r && 32'(tail_r) <= NL))
    else $error("ready queue pointers out of order");

  a_emit_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMOUT) |-> present_r[q_q_r[IW-1:0]])
    else $error("sorted node is not present");

  a_order_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ov_r) |-> (out_status_r == ST_OK))
    else $error("order beat with a failure status");

endmodule
